>>> src/alt_pkg.sv
// alt_pkg: shared types, constants and score helpers for the local aligner
// used by alt_req_if, alt_res_if, alt_cell and affine_local_align_traceback
`default_nettype none
package alt_pkg;

  localparam int TileSize   = 512;
  localparam int IdxW       = 9;
  localparam int DirAddrW   = 2 * IdxW;
  localparam int StepW      = 11;
  localparam int OpsPerWord = 32;
  localparam int MaxOps     = 1024;

  typedef logic signed [31:0] score_t;

  localparam score_t NegInf = 32'sh8000_0000;

  // request codes
  localparam logic [1:0] ReqLoadRef   = 2'd0;
  localparam logic [1:0] ReqLoadQuery = 2'd1;
  localparam logic [1:0] ReqStart     = 2'd2;
  localparam logic [1:0] ReqIgnored   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CfgSubA      = 3'd0;
  localparam logic [2:0] CfgSubC      = 3'd1;
  localparam logic [2:0] CfgSubG      = 3'd2;
  localparam logic [2:0] CfgSubT      = 3'd3;
  localparam logic [2:0] CfgSubN      = 3'd4;
  localparam logic [2:0] CfgGapOpen   = 3'd5;
  localparam logic [2:0] CfgGapExtend = 3'd6;
  localparam logic [2:0] CfgStepLimit = 3'd7;

  // traceback op codes
  localparam logic [1:0] OpNone  = 2'd0;
  localparam logic [1:0] OpDel   = 2'd1;
  localparam logic [1:0] OpIns   = 2'd2;
  localparam logic [1:0] OpMatch = 2'd3;

  localparam logic [2:0] BaseN = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CRD,
    ST_CCMP,
    ST_TRD,
    ST_TDAT
  } state_e;

  // one row entry: H, M and I of a column
  typedef struct packed {
    score_t h;
    score_t m;
    score_t i;
  } row_t;

  typedef struct packed {
    score_t                  hdiag;
    score_t                  up_m;
    score_t                  up_i;
    score_t                  left_m;
    score_t                  left_d;
    logic signed [7:0]       sub;
    logic signed [10:0]      open_pen;
    logic signed [10:0]      gap_ext;
  } cell_in_t;

  typedef struct packed {
    score_t     h;
    score_t     m;
    score_t     iv;
    score_t     dv;
    logic [3:0] dir;
  } cell_out_t;

  typedef struct packed {
    logic            kind;
    score_t          score;
    logic [IdxW-1:0] cell_ref;
    logic [IdxW-1:0] cell_query;
    logic [63:0]     ops_word;
    logic [5:0]      ops_count;
    logic            last;
  } res_t;

  // clamp a 33-bit sum to the score range
  function automatic score_t sat(input logic signed [32:0] v);
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = 33'sh0_7FFF_FFFF;
    lo = 33'sh1_8000_0000;
    if (v > hi) begin
      sat = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat = NegInf;
    end else begin
      sat = v[31:0];
    end
  endfunction

  function automatic score_t add_gap(input score_t a, input logic signed [10:0] g);
    add_gap = sat($signed({a[31], a}) + $signed({{22{g[10]}}, g}));
  endfunction

  function automatic score_t max2(input score_t a, input score_t b);
    max2 = (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

>>> src/alt_req_if.sv
// alt_req_if: request channel of the aligner (loads and starts)
// depends on alt_pkg for the index width
`default_nettype none
interface alt_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [alt_pkg::IdxW-1:0]   position;
  logic [2:0]                 base;
  logic [alt_pkg::IdxW-1:0]   ref_length;
  logic [alt_pkg::IdxW-1:0]   query_length;
  logic [alt_pkg::IdxW-1:0]   anchor_ref;
  logic [alt_pkg::IdxW-1:0]   anchor_query;
  logic                       reverse_dir;
  logic                       from_best;

  modport source (output valid, req_type, position, base, ref_length, query_length,
                  anchor_ref, anchor_query, reverse_dir, from_best, input ready);
  modport sink (input valid, req_type, position, base, ref_length, query_length,
                anchor_ref, anchor_query, reverse_dir, from_best, output ready);
endinterface
`default_nettype wire

>>> src/alt_res_if.sv
// alt_res_if: result channel of the aligner (header and packed ops)
// depends on alt_pkg for the index width
`default_nettype none
interface alt_res_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [31:0]         score;
  logic [alt_pkg::IdxW-1:0]   cell_ref;
  logic [alt_pkg::IdxW-1:0]   cell_query;
  logic [63:0]                ops_word;
  logic [5:0]                 ops_count;
  logic                       last;

  modport source (output valid, kind, score, cell_ref, cell_query, ops_word, ops_count,
                  last, input ready);
  modport sink (input valid, kind, score, cell_ref, cell_query, ops_word, ops_count,
                last, output ready);
endinterface
`default_nettype wire

>>> src/alt_cell.sv
// alt_cell: one cell of the affine-gap recurrence with its direction word
// depends on alt_pkg
`default_nettype none
module alt_cell (
  input  alt_pkg::cell_in_t  cell_i,
  output alt_pkg::cell_out_t cell_o
);

  alt_pkg::score_t m, io, ie, dop, de, iv, dv, h;
  logic [1:0]      st;

  always_comb begin
    // candidate scores
    m   = alt_pkg::sat($signed({cell_i.hdiag[31], cell_i.hdiag})
                       + $signed({{25{cell_i.sub[7]}}, cell_i.sub}));
    io  = alt_pkg::add_gap(cell_i.up_m, cell_i.open_pen);
    ie  = alt_pkg::add_gap(cell_i.up_i, cell_i.gap_ext);
    dop = alt_pkg::add_gap(cell_i.left_m, cell_i.open_pen);
    de  = alt_pkg::add_gap(cell_i.left_d, cell_i.gap_ext);
    iv  = alt_pkg::max2(io, ie);
    dv  = alt_pkg::max2(dop, de);
    h   = alt_pkg::max2(alt_pkg::max2(m, iv), alt_pkg::max2(dv, '0));

    // traceback state of H
    if (m <= 0 && iv <= 0 && dv <= 0) begin
      st = alt_pkg::OpNone;
    end else if (m >= iv) begin
      st = (m >= dv) ? alt_pkg::OpMatch : alt_pkg::OpDel;
    end else begin
      st = (iv >= dv) ? alt_pkg::OpIns : alt_pkg::OpDel;
    end

    cell_o.h   = h;
    cell_o.m   = m;
    cell_o.iv  = iv;
    cell_o.dv  = dv;
    cell_o.dir = {io >= ie, dop >= de, st};
  end

endmodule
`default_nettype wire

>>> src/affine_local_align_traceback.sv
// affine_local_align_traceback: local alignment with affine gaps and traceback
// depends on alt_pkg, alt_req_if, alt_res_if and alt_cell
//
// Usage: req_i carries base loads and start requests, res_o carries results,
// both valid/ready; a transfer happens when valid and ready are high.
// A load writes one base in the transfer cycle; loads take one per cycle.
// A start fills the score matrix one cell at a time, each cell taking a
// synchronous row/query memory read state and then a compute and write-back
// state, after a row-init sweep over the query_length columns. Then each
// traceback op takes a direction memory read, then a step, giving a header
// result and one result per 32 ops; the last result has last set.
// req_i.ready is high only while no start is in flight.
// Results go through one output register; when the receiver stalls, the
// traceback holds until the register is free, nothing is dropped.
// Reset clears the control state and the configuration registers (step limit
// 1024); base, direction and row memories hold garbage until written.
// Configuration writes go through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// the user must keep to this, the block itself does not enforce it.
`default_nettype none
module affine_local_align_traceback (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [39:0] cfg_data_i,
  alt_req_if.sink          req_i,
  alt_res_if.source        res_o
);

  localparam int IW = alt_pkg::IdxW;

  // configuration
  logic [39:0]        sub_q [5];
  logic signed [10:0] gopen_q, gext_q;
  logic [10:0]        limit_q;

  // memories
  logic [2:0]          ref_mem [alt_pkg::TileSize];
  logic [2:0]          qry_mem [alt_pkg::TileSize];
  logic [3:0]          dir_mem [alt_pkg::TileSize * alt_pkg::TileSize];
  alt_pkg::row_t       row_mem [alt_pkg::TileSize];
  logic [2:0]          ref_rd_q, qry_rd_q;
  logic [3:0]          dir_rd_q;
  alt_pkg::row_t       row_rd_q;

  // control and datapath registers
  alt_pkg::state_e     state_q, state_d;
  logic [IW-1:0]       rl_q, rl_d, ql_q, ql_d, ar_q, ar_d, aq_q, aq_d;
  logic                rev_q, rev_d, bmode_q, bmode_d;
  logic [IW-1:0]       i_q, i_d, j_q, j_d;
  alt_pkg::score_t     hdiag_q, hdiag_d, lm_q, lm_d, ld_q, ld_d;
  alt_pkg::score_t     best_q, best_d, pos_q, pos_d;
  logic [IW-1:0]       bi_q, bi_d, bj_q, bj_d, ci_q, ci_d, cj_q, cj_d;
  logic [alt_pkg::StepW-1:0] is_q, is_d, js_q, js_d, n_q, n_d;
  logic [1:0]          st_q, st_d;
  logic                need_q, need_d, hdr_q, hdr_d;
  logic [63:0]         word_q, word_d;
  logic [5:0]          wcnt_q, wcnt_d;
  logic                ov_q, ov_d;
  alt_pkg::res_t       res_q, res_d;

  // memory access controls
  logic                ref_we, qry_we, row_we, dir_we;
  alt_pkg::row_t       row_wdata;
  logic [IW-1:0]       ref_raddr, qry_raddr;
  logic [alt_pkg::DirAddrW-1:0] dir_raddr, dir_waddr;

  // cell
  alt_pkg::cell_in_t   cin;
  alt_pkg::cell_out_t  cout;
  logic [2:0]          qb, rb;

  logic                accept, slot_free, in_rng, cont;
  logic [3:0]          dcur;
  logic [1:0]          st_now;
  alt_pkg::score_t     best_n;
  logic [IW-1:0]       bi_n, bj_n;

  alt_cell u_cell (
    .cell_i (cin),
    .cell_o (cout)
  );

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !ov_q || res_o.ready;
  assign req_i.ready = (state_q == alt_pkg::ST_IDLE);

  assign ref_we = accept && (req_i.req_type == alt_pkg::ReqLoadRef);
  assign qry_we = accept && (req_i.req_type == alt_pkg::ReqLoadQuery);

  // read addresses follow the current indexes
  assign ref_raddr = rev_q ? IW'(rl_q - i_q) : IW'(i_q - 1'b1);
  assign qry_raddr = rev_q ? IW'(ql_q - j_q) : IW'(j_q - 1'b1);
  assign dir_raddr = {IW'(ci_q - 1'b1), IW'(cj_q - 1'b1)};
  assign dir_waddr = {IW'(i_q - 1'b1), IW'(j_q - 1'b1)};

  // base memories
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[req_i.position] <= req_i.base;
    end
    if (qry_we) begin
      qry_mem[req_i.position] <= req_i.base;
    end
    ref_rd_q <= ref_mem[ref_raddr];
    qry_rd_q <= qry_mem[qry_raddr];
  end

  // score row memory
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[j_q] <= row_wdata;
    end
    row_rd_q <= row_mem[j_q];
  end

  // direction memory
  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= cout.dir;
    end
    dir_rd_q <= dir_mem[dir_raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) begin
        sub_q[k] <= '0;
      end
      gopen_q <= '0;
      gext_q  <= '0;
      limit_q <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        alt_pkg::CfgSubA:      sub_q[0] <= cfg_data_i;
        alt_pkg::CfgSubC:      sub_q[1] <= cfg_data_i;
        alt_pkg::CfgSubG:      sub_q[2] <= cfg_data_i;
        alt_pkg::CfgSubT:      sub_q[3] <= cfg_data_i;
        alt_pkg::CfgSubN:      sub_q[4] <= cfg_data_i;
        alt_pkg::CfgGapOpen:   gopen_q  <= cfg_data_i[10:0];
        alt_pkg::CfgGapExtend: gext_q   <= cfg_data_i[10:0];
        alt_pkg::CfgStepLimit: limit_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // cell inputs
  always_comb begin
    qb = (qry_rd_q > alt_pkg::BaseN) ? alt_pkg::BaseN : qry_rd_q;
    rb = (ref_rd_q > alt_pkg::BaseN) ? alt_pkg::BaseN : ref_rd_q;
    cin.hdiag    = hdiag_q;
    cin.up_m     = row_rd_q.m;
    cin.up_i     = row_rd_q.i;
    cin.left_m   = lm_q;
    cin.left_d   = ld_q;
    cin.sub      = sub_q[qb][8*rb +: 8];
    cin.open_pen = gopen_q;
    cin.gap_ext  = gext_q;
  end

  // control and traceback
  always_comb begin
    state_d = state_q;
    rl_d = rl_q; ql_d = ql_q; ar_d = ar_q; aq_d = aq_q;
    rev_d = rev_q; bmode_d = bmode_q;
    i_d = i_q; j_d = j_q;
    hdiag_d = hdiag_q; lm_d = lm_q; ld_d = ld_q;
    best_d = best_q; pos_d = pos_q; bi_d = bi_q; bj_d = bj_q;
    ci_d = ci_q; cj_d = cj_q; is_d = is_q; js_d = js_q; n_d = n_q;
    st_d = st_q; need_d = need_q; hdr_d = hdr_q;
    word_d = word_q; wcnt_d = wcnt_q;
    ov_d = ov_q && !res_o.ready;
    res_d = res_q;
    row_we = 1'b0;
    row_wdata = '{h: '0, m: '0, i: alt_pkg::NegInf};
    dir_we = 1'b0;

    // best tracking for the cell in flight
    if (cout.h >= best_q) begin
      best_n = cout.h; bi_n = i_q; bj_n = j_q;
    end else begin
      best_n = best_q; bi_n = bi_q; bj_n = bj_q;
    end

    // traceback view of the current cell
    in_rng = (ci_q != '0) && (cj_q != '0) && (ci_q <= rl_q) && (cj_q <= ql_q);
    dcur   = in_rng ? dir_rd_q : 4'd0;
    st_now = need_q ? dcur[1:0] : st_q;
    cont   = (st_now != alt_pkg::OpNone) && (ci_q != '0) && (cj_q != '0)
             && (is_q < limit_q) && (js_q < limit_q)
             && (n_q < alt_pkg::StepW'(alt_pkg::MaxOps));

    case (state_q)
      alt_pkg::ST_IDLE: begin
        if (accept && req_i.req_type == alt_pkg::ReqStart) begin
          rl_d = req_i.ref_length; ql_d = req_i.query_length;
          ar_d = req_i.anchor_ref; aq_d = req_i.anchor_query;
          rev_d = req_i.reverse_dir; bmode_d = req_i.from_best;
          best_d = '0; pos_d = '0; bi_d = '0; bj_d = '0;
          is_d = '0; js_d = '0; n_d = '0;
          need_d = 1'b1; hdr_d = 1'b1; word_d = '0; wcnt_d = '0;
          st_d = alt_pkg::OpNone;
          if (req_i.ref_length != '0 && req_i.query_length != '0) begin
            j_d = IW'(1);
            state_d = alt_pkg::ST_INIT;
          end else begin
            ci_d = req_i.from_best ? '0 : req_i.anchor_ref;
            cj_d = req_i.from_best ? '0 : req_i.anchor_query;
            state_d = alt_pkg::ST_TRD;
          end
        end
      end

      // clear the row, one column per cycle
      alt_pkg::ST_INIT: begin
        row_we = 1'b1;
        if (j_q == ql_q) begin
          i_d = IW'(1); j_d = IW'(1);
          hdiag_d = '0; lm_d = '0; ld_d = alt_pkg::NegInf;
          state_d = alt_pkg::ST_CRD;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      // wait for row, query and reference reads
      alt_pkg::ST_CRD: begin
        state_d = alt_pkg::ST_CCMP;
      end

      // compute one cell and write it back
      alt_pkg::ST_CCMP: begin
        row_we = 1'b1;
        row_wdata = '{h: cout.h, m: cout.m, i: cout.iv};
        dir_we = 1'b1;
        best_d = best_n; bi_d = bi_n; bj_d = bj_n;
        if (i_q == ar_q && j_q == aq_q) begin
          pos_d = cout.h;
        end
        hdiag_d = row_rd_q.h; lm_d = cout.m; ld_d = cout.dv;
        state_d = alt_pkg::ST_CRD;
        if (j_q == ql_q) begin
          if (i_q == rl_q) begin
            ci_d = bmode_q ? bi_n : ar_q;
            cj_d = bmode_q ? bj_n : aq_q;
            state_d = alt_pkg::ST_TRD;
          end else begin
            i_d = i_q + 1'b1; j_d = IW'(1);
            hdiag_d = '0; lm_d = '0; ld_d = alt_pkg::NegInf;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      // wait for the direction read
      alt_pkg::ST_TRD: begin
        state_d = alt_pkg::ST_TDAT;
      end

      // one traceback step, header and word emission
      alt_pkg::ST_TDAT: begin
        if (hdr_q) begin
          if (slot_free) begin
            ov_d = 1'b1;
            res_d = '0;
            res_d.kind = 1'b0;
            res_d.score = bmode_q ? best_q : pos_q;
            res_d.cell_ref = bmode_q ? bi_q : ar_q;
            res_d.cell_query = bmode_q ? bj_q : aq_q;
            res_d.last = !cont;
            hdr_d = 1'b0;
            if (!cont) begin
              state_d = alt_pkg::ST_IDLE;
            end
          end
        end else if (cont) begin
          if (wcnt_q == 6'(alt_pkg::OpsPerWord)) begin
            if (slot_free) begin
              ov_d = 1'b1;
              res_d = '0;
              res_d.kind = 1'b1;
              res_d.ops_word = word_q;
              res_d.ops_count = wcnt_q;
              res_d.last = 1'b0;
              word_d = '0; wcnt_d = '0;
            end
          end else begin
            word_d[2*wcnt_q[4:0] +: 2] = st_now;
            wcnt_d = wcnt_q + 1'b1;
            n_d = n_q + 1'b1;
            state_d = alt_pkg::ST_TRD;
            case (st_now)
              alt_pkg::OpMatch: begin
                need_d = 1'b1;
                ci_d = ci_q - 1'b1; cj_d = cj_q - 1'b1;
                is_d = is_q + 1'b1; js_d = js_q + 1'b1;
              end
              alt_pkg::OpIns: begin
                need_d = 1'b0;
                st_d = dcur[3] ? alt_pkg::OpMatch : alt_pkg::OpIns;
                ci_d = ci_q - 1'b1; is_d = is_q + 1'b1;
              end
              default: begin
                need_d = 1'b0;
                st_d = dcur[2] ? alt_pkg::OpMatch : alt_pkg::OpDel;
                cj_d = cj_q - 1'b1; js_d = js_q + 1'b1;
              end
            endcase
          end
        end else if (slot_free) begin
          ov_d = 1'b1;
          res_d = '0;
          res_d.kind = 1'b1;
          res_d.ops_word = word_q;
          res_d.ops_count = wcnt_q;
          res_d.last = 1'b1;
          state_d = alt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = alt_pkg::ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alt_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      hdr_q   <= 1'b0;
      need_q  <= 1'b0;
      st_q    <= alt_pkg::OpNone;
      n_q     <= '0;
      is_q    <= '0;
      js_q    <= '0;
      wcnt_q  <= '0;
      best_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      hdr_q   <= hdr_d;
      need_q  <= need_d;
      st_q    <= st_d;
      n_q     <= n_d;
      is_q    <= is_d;
      js_q    <= js_d;
      wcnt_q  <= wcnt_d;
      best_q  <= best_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rl_q <= rl_d; ql_q <= ql_d; ar_q <= ar_d; aq_q <= aq_d;
    rev_q <= rev_d; bmode_q <= bmode_d;
    hdiag_q <= hdiag_d; lm_q <= lm_d; ld_q <= ld_d;
    pos_q <= pos_d; bi_q <= bi_d; bj_q <= bj_d;
    ci_q <= ci_d; cj_q <= cj_d;
    word_q <= word_d;
    res_q <= res_d;
  end

  // result channel
  assign res_o.valid      = ov_q;
  assign res_o.kind       = res_q.kind;
  assign res_o.score      = res_q.score;
  assign res_o.cell_ref   = res_q.cell_ref;
  assign res_o.cell_query = res_q.cell_query;
  assign res_o.ops_word   = res_q.ops_word;
  assign res_o.ops_count  = res_q.ops_count;
  assign res_o.last       = res_q.last;

endmodule
`default_nettype wire

>>> tb/sv/affine_local_align_traceback_tb.sv
// affine_local_align_traceback_tb: self-checking testbench of the local aligner
// depends on alt_pkg, alt_req_if, alt_res_if and affine_local_align_traceback
`timescale 1ns / 100ps
`default_nettype none
module affine_local_align_traceback_tb;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [39:0] cfg_data_i;

  alt_req_if req_if ();
  alt_res_if res_if ();

  affine_local_align_traceback dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .res_o      (res_if.source)
  );

  // predictor state
  logic [39:0]         sub_rows [5];
  logic signed [10:0]  open_pen;
  logic signed [10:0]  gap_ext;
  logic [10:0]         step_lim;
  logic [2:0]          ref_bases [alt_pkg::TileSize];
  logic [2:0]          qry_bases [alt_pkg::TileSize];
  logic [3:0]          dir_mem [alt_pkg::TileSize*alt_pkg::TileSize];
  int                  fill_rl;
  int                  fill_ql;
  longint              row_h [alt_pkg::TileSize+1];
  longint              row_m [alt_pkg::TileSize+1];
  longint              row_i [alt_pkg::TileSize+1];
  longint              row_d [alt_pkg::TileSize+1];

  alt_pkg::res_t expected_results [$];
  int     error_count;
  longint cycle_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_off_cycles;
  int     max_len;

  localparam longint ScoreMax = 64'sd2147483647;
  localparam longint ScoreMin = -64'sd2147483648;
  localparam longint CycleLimit = 64'd6000000;

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cycle watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL affine_local_align_traceback");
      $finish;
    end
  end

  function automatic longint clamp_score(input longint v);
    if (v > ScoreMax) return ScoreMax;
    if (v < ScoreMin) return ScoreMin;
    return v;
  endfunction

  function automatic longint pair_score(input int q, input int r);
    logic [7:0] b;
    if (q > 4) q = 4;
    if (r > 4) r = 4;
    b = sub_rows[q][8*r +: 8];
    return longint'($signed(b));
  endfunction

  function automatic int dir_of(input int i, input int j);
    if (i == 0 || j == 0 || i > fill_rl || j > fill_ql) return 0;
    return int'(dir_mem[(i-1)*alt_pkg::TileSize + (j-1)]);
  endfunction

  // fill the matrix, trace back and queue the header and ops results
  task automatic predict_alignment(input int rl_in, input int ql_in, input int ar,
                                   input int aq, input bit rev, input bit from_best);
    int rl, ql, i, j, bi, bj, ci, cj, n, st, is, js, nres, k, cnt, rb, qb, d;
    longint best, anchor_score, hdiag, m, io, ie, dop, de, iv, dv, h;
    logic [63:0] words [alt_pkg::MaxOps/32];
    alt_pkg::res_t r;
    rl = (rl_in > alt_pkg::TileSize-1) ? alt_pkg::TileSize-1 : rl_in;
    ql = (ql_in > alt_pkg::TileSize-1) ? alt_pkg::TileSize-1 : ql_in;
    fill_rl = rl;
    fill_ql = ql;
    best = 0; anchor_score = 0; bi = 0; bj = 0;
    for (j = 0; j <= ql; j++) begin
      row_h[j] = 0; row_m[j] = 0; row_i[j] = ScoreMin; row_d[j] = ScoreMin;
    end
    for (i = 1; i <= rl; i++) begin
      rb = rev ? ref_bases[rl-i] : ref_bases[i-1];
      hdiag = row_h[0];
      for (j = 1; j <= ql; j++) begin
        qb = rev ? qry_bases[ql-j] : qry_bases[j-1];
        m = clamp_score(hdiag + pair_score(qb, rb));
        io = clamp_score(row_m[j] + open_pen);
        ie = clamp_score(row_i[j] + gap_ext);
        dop = clamp_score(row_m[j-1] + open_pen);
        de = clamp_score(row_d[j-1] + gap_ext);
        iv = (io > ie) ? io : ie;
        dv = (dop > de) ? dop : de;
        h = 0;
        if (m > h) h = m;
        if (iv > h) h = iv;
        if (dv > h) h = dv;
        if (m <= 0 && iv <= 0 && dv <= 0) d = alt_pkg::OpNone;
        else if (m >= iv) d = (m >= dv) ? alt_pkg::OpMatch : alt_pkg::OpDel;
        else d = (iv >= dv) ? alt_pkg::OpIns : alt_pkg::OpDel;
        if (io >= ie) d += 8;
        if (dop >= de) d += 4;
        dir_mem[(i-1)*alt_pkg::TileSize + (j-1)] = d[3:0];
        hdiag = row_h[j];
        row_h[j] = h; row_m[j] = m; row_i[j] = iv; row_d[j] = dv;
        if (h >= best) begin
          best = h; bi = i; bj = j;
        end
        if (i == ar && j == aq) anchor_score = h;
      end
    end
    ci = from_best ? bi : ar;
    cj = from_best ? bj : aq;
    foreach (words[w]) words[w] = '0;
    n = 0; is = 0; js = 0;
    st = dir_of(ci, cj) & 3;
    while (st != alt_pkg::OpNone && ci != 0 && cj != 0 && is < step_lim && js < step_lim
           && n < alt_pkg::MaxOps) begin
      words[n/32][2*(n%32) +: 2] = st[1:0];
      n++;
      if (st == alt_pkg::OpMatch) begin
        st = dir_of(ci-1, cj-1) & 3;
        ci--; cj--; is++; js++;
      end else if (st == alt_pkg::OpIns) begin
        st = (dir_of(ci, cj) & 8) ? alt_pkg::OpMatch : alt_pkg::OpIns;
        ci--; is++;
      end else begin
        st = (dir_of(ci, cj) & 4) ? alt_pkg::OpMatch : alt_pkg::OpDel;
        cj--; js++;
      end
    end
    nres = 1 + (n + 31) / 32;
    r = '0;
    r.score = from_best ? best[31:0] : anchor_score[31:0];
    r.cell_ref = from_best ? bi[8:0] : ar[8:0];
    r.cell_query = from_best ? bj[8:0] : aq[8:0];
    r.last = (nres == 1);
    expected_results.push_back(r);
    for (k = 1; k < nres; k++) begin
      cnt = n - (k-1)*32;
      if (cnt > 32) cnt = 32;
      r = '0;
      r.kind = 1'b1;
      r.ops_word = words[k-1];
      r.ops_count = cnt[5:0];
      r.last = (k == nres-1);
      expected_results.push_back(r);
    end
  endtask

  // send one request, then update the predictor once it is transferred
  task automatic send_request(input logic [1:0] rtype, input int pos, input int b,
                              input int rl, input int ql, input int ar, input int aq,
                              input bit rev, input bit from_best);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= rtype;
    req_if.position     <= pos[8:0];
    req_if.base         <= b[2:0];
    req_if.ref_length   <= rl[8:0];
    req_if.query_length <= ql[8:0];
    req_if.anchor_ref   <= ar[8:0];
    req_if.anchor_query <= aq[8:0];
    req_if.reverse_dir  <= rev;
    req_if.from_best    <= from_best;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (rtype == alt_pkg::ReqLoadRef) ref_bases[pos] = b[2:0];
    else if (rtype == alt_pkg::ReqLoadQuery) qry_bases[pos] = b[2:0];
    else if (rtype == alt_pkg::ReqStart) predict_alignment(rl, ql, ar, aq, rev, from_best);
  endtask

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      res_if.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    alt_pkg::res_t got;
    alt_pkg::res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind = res_if.kind;
      got.score = res_if.score;
      got.cell_ref = res_if.cell_ref;
      got.cell_query = res_if.cell_query;
      got.ops_word = res_if.ops_word;
      got.ops_count = res_if.ops_count;
      got.last = res_if.last;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind)
          $display("%0t: kind exp %0d got %0d", $realtime, want.kind, got.kind);
        if (got.score != want.score)
          $display("%0t: score exp %0d got %0d", $realtime, want.score, got.score);
        if (got.cell_ref != want.cell_ref)
          $display("%0t: cell_ref exp %0d got %0d", $realtime, want.cell_ref,
                   got.cell_ref);
        if (got.cell_query != want.cell_query)
          $display("%0t: cell_query exp %0d got %0d", $realtime, want.cell_query,
                   got.cell_query);
        if (got.ops_word != want.ops_word)
          $display("%0t: ops_word exp %h got %h", $realtime, want.ops_word,
                   got.ops_word);
        if (got.ops_count != want.ops_count)
          $display("%0t: ops_count exp %0d got %0d", $realtime, want.ops_count,
                   got.ops_count);
        if (got.last != want.last)
          $display("%0t: last exp %0d got %0d", $realtime, want.last, got.last);
        if (got != want) error_count++;
      end
    end
  end

  // register write while idle, predictor follows
  task automatic write_reg(input logic [2:0] idx, input logic [39:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= alt_pkg::CfgSubN) sub_rows[idx] = value;
    else if (idx == alt_pkg::CfgGapOpen) open_pen = value[10:0];
    else if (idx == alt_pkg::CfgGapExtend) gap_ext = value[10:0];
    else step_lim = value[10:0];
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [39:0] sub_row(input int off);
    logic [39:0] v;
    for (int k = 0; k < 5; k++) v[8*k +: 8] = 8'(off);
    return v;
  endfunction

  // typical scoring: match bonus on the diagonal, mismatch penalty elsewhere
  task automatic set_scoring(input int mat, input int mis, input int go, input int ge,
                             input int lim);
    logic [39:0] v;
    for (int q = 0; q < 5; q++) begin
      v = sub_row(mis);
      if (q < 4) v[8*q +: 8] = 8'(mat);
      write_reg(q[2:0], v);
    end
    write_reg(alt_pkg::CfgGapOpen, 40'(go));
    write_reg(alt_pkg::CfgGapExtend, 40'(ge));
    write_reg(alt_pkg::CfgStepLimit, 40'(lim));
  endtask

  task automatic load_sequences(input int rl, input int ql, input bit fully_random);
    for (int p = 0; p < rl; p++)
      send_request(alt_pkg::ReqLoadRef, p,
                   fully_random ? $urandom_range(7) : $urandom_range(3),
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int p = 0; p < ql; p++)
      send_request(alt_pkg::ReqLoadQuery, p,
                   fully_random ? $urandom_range(7) : $urandom_range(3),
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic start_align(input int rl, input int ql, input int ar, input int aq,
                             input bit rev, input bit from_best);
    send_request(alt_pkg::ReqStart, $urandom, $urandom, rl, ql, ar, aq, rev, from_best);
  endtask

  // directed: extremes of fields, both directions, both modes, ignored requests
  task automatic test_directed();
    set_scoring(2, -3, -5, -1, 1024);
    load_sequences(12, 10, 1'b1);
    start_align(12, 10, 1, 1, 1'b0, 1'b1);
    start_align(12, 10, 12, 10, 1'b1, 1'b0);
    start_align(0, 0, 0, 0, 1'b0, 1'b1);
    start_align(12, 10, 0, 5, 1'b0, 1'b0);
    start_align(12, 10, 511, 511, 1'b1, 1'b0);
    // unknown request, which is ignored, and loads at a position beyond the lengths
    send_request(alt_pkg::ReqIgnored, 511, 7, 511, 511, 511, 511, 1'b1, 1'b1);
    send_request(alt_pkg::ReqLoadRef, 511, 7, 0, 0, 0, 0, 1'b0, 1'b0);
    send_request(alt_pkg::ReqLoadQuery, 511, 4, 0, 0, 0, 0, 1'b0, 1'b0);
    wait_drained();
  endtask

  // extremes of scoring, saturation and step limits
  task automatic test_extreme_scoring();
    write_reg(alt_pkg::CfgSubA, 40'hFF_FFFF_FFFF);
    write_reg(alt_pkg::CfgSubC, 40'h7F_7F7F_7F7F);
    write_reg(alt_pkg::CfgSubG, 40'h80_807F_8080);
    write_reg(alt_pkg::CfgSubT, 40'h7F_8000_7F00);
    write_reg(alt_pkg::CfgSubN, 40'h01_0203_0405);
    write_reg(alt_pkg::CfgGapOpen, 40'h400);
    write_reg(alt_pkg::CfgGapExtend, 40'h400);
    write_reg(alt_pkg::CfgStepLimit, 40'd0);
    start_align(12, 10, 12, 10, 1'b0, 1'b1);
    wait_drained();
    write_reg(alt_pkg::CfgGapOpen, 40'd0);
    write_reg(alt_pkg::CfgGapExtend, 40'd0);
    write_reg(alt_pkg::CfgStepLimit, 40'd3);
    start_align(12, 10, 6, 6, 1'b1, 1'b1);
    wait_drained();
    // long identical sequences give multi-word ops
    set_scoring(127, -128, 0, 0, 1024);
    for (int p = 0; p < 70; p++) begin
      send_request(alt_pkg::ReqLoadRef, p, p % 4, 0, 0, 0, 0, 1'b0, 1'b0);
      send_request(alt_pkg::ReqLoadQuery, p, p % 4, 0, 0, 0, 0, 1'b0, 1'b0);
    end
    start_align(70, 70, 70, 70, 1'b0, 1'b1);
    wait_drained();
    write_reg(alt_pkg::CfgStepLimit, 40'd40);
    start_align(70, 70, 70, 70, 1'b1, 1'b0);
    wait_drained();
  endtask

  // random sequences and starts under one idling setting
  task automatic test_random_phase(input int n_starts, input int snd, input int rcv);
    int rl, ql;
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    set_scoring($urandom_range(1, 6), -int'($urandom_range(0, 6)),
                -int'($urandom_range(0, 12)), -int'($urandom_range(0, 4)),
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : 1024);
    for (int s = 0; s < n_starts; s++) begin
      rl = $urandom_range(1, max_len);
      ql = $urandom_range(1, max_len);
      load_sequences(rl, ql, $urandom_range(3) == 0);
      start_align(rl, ql, $urandom_range(0, rl + 1), $urandom_range(0, ql + 1),
                  $urandom, $urandom_range(2) != 0);
      if ($urandom_range(5) == 0)
        send_request(alt_pkg::ReqIgnored, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end
    wait_drained();
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles <= 3000;
    for (int s = 0; s < 4; s++) begin
      load_sequences(8, 8, 1'b0);
      start_align(8, 8, 8, 8, 1'b0, 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    max_len = 12;
    for (int k = 0; k < 5; k++) sub_rows[k] = '0;
    open_pen = '0;
    gap_ext = '0;
    step_lim = 11'd1024;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = alt_pkg::ReqLoadRef;
    req_if.position = '0;
    req_if.base = '0;
    req_if.ref_length = '0;
    req_if.query_length = '0;
    req_if.anchor_ref = '0;
    req_if.anchor_query = '0;
    req_if.reverse_dir = 1'b0;
    req_if.from_best = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extreme_scoring();
    test_random_phase(4, 0, 0);
    test_random_phase(4, 46, 0);
    test_random_phase(4, 0, 46);
    test_random_phase(4, 22, 22);
    test_backpressure();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS affine_local_align_traceback");
    end else begin
      $display("FAIL affine_local_align_traceback");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
src/alt_pkg.sv
src/alt_req_if.sv
src/alt_res_if.sv
src/alt_cell.sv
src/affine_local_align_traceback.sv
tb/sv/affine_local_align_traceback_tb.sv
